/* sv/lpc_pkg.sv */
// ----------------------------------------------------------------------------
// lpc_pkg
// Shared constants and controller/datapath handoff types for the page cache
// tag lookup.
// ----------------------------------------------------------------------------
package lpc_pkg;

    localparam int KEY_W      = 64;
    localparam int SLOT_OUT_W = 6;
    localparam int CAP_W      = 7;
    localparam int DEF_SLOTS  = 64;

    localparam logic [CAP_W-1:0] ACTIVE_RESET = 7'd64;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;      // latch request key, restart scan
        logic scan;      // issue one key read at the scan pointer
        logic sel_hit;   // select the matching slot
        logic sel_tail;  // select the least recent slot for eviction
        logic unlink;    // retag on evict, unhook selected slot from the list
        logic relink;    // put selected slot at the head of the list
        logic fill;      // take the next free slot
    } lpc_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic empty;     // no slot in use
        logic match;     // registered compare hit
        logic last;      // registered compare was the last used slot
        logic room;      // fewer slots in use than the capacity
        logic sel_head;  // selected slot already most recent
    } lpc_status_t;

endpackage

/* sv/lpc_ctrl.sv */
// ----------------------------------------------------------------------------
// lpc_ctrl
// Sequencer for one lookup: key scan, then fill or move-to-front of the
// selected slot.
// ----------------------------------------------------------------------------
module lpc_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  lpc_pkg::lpc_status_t status,
    output lpc_pkg::lpc_cmd_t    cmd,
    output logic                 busy,
    output logic                 done
);
    import lpc_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SCAN = 3'd1;
    localparam logic [2:0] ST_FILL = 3'd2;
    localparam logic [2:0] ST_RD   = 3'd3;
    localparam logic [2:0] ST_W1   = 3'd4;
    localparam logic [2:0] ST_W2   = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       done_reg;
    logic       done_next;

    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = status.empty ? ST_FILL : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                priority if (status.match)
                begin
                    cmd.sel_hit = 1'b1;
                    state_next  = ST_RD;
                end
                else if (status.last)
                begin
                    if (status.room)
                    begin
                        state_next = ST_FILL;
                    end
                    else
                    begin
                        cmd.sel_tail = 1'b1;
                        state_next   = ST_RD;
                    end
                end
                else
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_FILL:
            begin
                cmd.fill   = 1'b1;
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end
            ST_RD:
            begin
                state_next = ST_W1;
            end
            ST_W1:
            begin
                cmd.unlink = 1'b1;
                if (status.sel_head)
                begin
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_W2;
                end
            end
            ST_W2:
            begin
                cmd.relink = 1'b1;
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;

endmodule

/* sv/lpc_datapath.sv */
// ----------------------------------------------------------------------------
// lpc_datapath
// Key store, recency list (doubly linked, head most recent), use count,
// capacity register and result registers.
// ----------------------------------------------------------------------------
module lpc_datapath #(
    parameter int SLOTS = lpc_pkg::DEF_SLOTS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  lpc_pkg::lpc_cmd_t              cmd,
    output lpc_pkg::lpc_status_t           status,
    input  logic [lpc_pkg::KEY_W-1:0]      page_key,
    input  logic                           cfg_we,
    input  logic [lpc_pkg::CAP_W-1:0]      cfg_data,
    output logic                           res_hit,
    output logic [lpc_pkg::SLOT_OUT_W-1:0] res_slot,
    output logic                           res_evicted,
    output logic [lpc_pkg::KEY_W-1:0]      res_evicted_key
);
    import lpc_pkg::*;

    localparam int SW = $clog2(SLOTS);
    localparam int UW = $clog2(SLOTS + 1);

    logic [KEY_W-1:0] key_mem  [SLOTS];
    logic [SW-1:0]    prev_mem [SLOTS];
    logic [SW-1:0]    next_mem [SLOTS];

    logic [CAP_W-1:0] active_reg;
    logic [UW-1:0]    used_reg;
    logic [UW-1:0]    scan_reg;
    logic [KEY_W-1:0] req_key_reg;
    logic [KEY_W-1:0] rd_key_reg;
    logic [SW-1:0]    rd_slot_reg;
    logic             rd_vld_reg;
    logic [SW-1:0]    sel_reg;
    logic [SW-1:0]    prev_q_reg;
    logic [SW-1:0]    next_q_reg;
    logic [SW-1:0]    head_reg;
    logic [SW-1:0]    tail_reg;
    logic             hit_reg;
    logic             evicted_reg;
    logic [SW-1:0]    slot_reg;
    logic [KEY_W-1:0] evkey_reg;

    logic [UW-1:0]    cap;
    logic             issue;
    logic [SW-1:0]    rd_addr;
    logic [SW-1:0]    fill_slot;
    logic             sel_head;
    logic             sel_tail;

    logic             key_we;
    logic [SW-1:0]    key_wa;
    logic             prev_we;
    logic [SW-1:0]    prev_wa;
    logic [SW-1:0]    prev_wd;
    logic             next_we;
    logic [SW-1:0]    next_wa;
    logic [SW-1:0]    next_wd;

    // capacity clamped to one..SLOTS
    always_comb
    begin
        priority if (active_reg == '0)
            cap = UW'(1);
        else if (int'(active_reg) > SLOTS)
            cap = UW'(SLOTS);
        else
            cap = UW'(active_reg);
    end

    assign issue     = cmd.scan && (scan_reg < used_reg);
    assign rd_addr   = issue ? scan_reg[SW-1:0] : sel_reg;
    assign fill_slot = used_reg[SW-1:0];
    assign sel_head  = (sel_reg == head_reg);
    assign sel_tail  = (sel_reg == tail_reg);

    assign status.empty    = (used_reg == '0);
    assign status.match    = rd_vld_reg && (rd_key_reg == req_key_reg);
    assign status.last     = rd_vld_reg && ((UW'(rd_slot_reg) + UW'(1)) == used_reg);
    assign status.room     = (used_reg < cap);
    assign status.sel_head = sel_head;

    // memory write ports
    always_comb
    begin
        key_we  = 1'b0;
        key_wa  = sel_reg;
        prev_we = 1'b0;
        prev_wa = head_reg;
        prev_wd = sel_reg;
        next_we = 1'b0;
        next_wa = sel_reg;
        next_wd = head_reg;
        priority if (cmd.fill)
        begin
            key_we  = 1'b1;
            key_wa  = fill_slot;
            prev_we = !status.empty;
            prev_wd = fill_slot;
            next_we = !status.empty;
            next_wa = fill_slot;
        end
        else if (cmd.unlink)
        begin
            key_we  = evicted_reg;
            // neighbors of the selected slot point past it
            prev_we = !sel_head && !sel_tail;
            prev_wa = next_q_reg;
            prev_wd = prev_q_reg;
            next_we = !sel_head;
            next_wa = prev_q_reg;
            next_wd = next_q_reg;
        end
        else if (cmd.relink)
        begin
            prev_we = 1'b1;
            next_we = 1'b1;
        end
        else
        begin
            key_we = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (key_we)
            key_mem[key_wa] <= req_key_reg;
        rd_key_reg <= key_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (prev_we)
            prev_mem[prev_wa] <= prev_wd;
        prev_q_reg <= prev_mem[sel_reg];
    end

    always_ff @(posedge clk)
    begin
        if (next_we)
            next_mem[next_wa] <= next_wd;
        next_q_reg <= next_mem[sel_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= ACTIVE_RESET;
            used_reg   <= '0;
            scan_reg   <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                active_reg <= cfg_data;
            if (cmd.fill)
                used_reg <= used_reg + UW'(1);
            if (cmd.load)
                scan_reg <= '0;
            else if (issue)
                scan_reg <= scan_reg + UW'(1);
            rd_vld_reg <= issue;
        end
    end

    // payload and list pointers, meaningful only while slots are in use
    always_ff @(posedge clk)
    begin
        rd_slot_reg <= rd_addr;
        if (cmd.load)
            req_key_reg <= page_key;
        if (cmd.sel_hit)
        begin
            sel_reg     <= rd_slot_reg;
            slot_reg    <= rd_slot_reg;
            hit_reg     <= 1'b1;
            evicted_reg <= 1'b0;
        end
        if (cmd.sel_tail)
        begin
            sel_reg     <= tail_reg;
            slot_reg    <= tail_reg;
            hit_reg     <= 1'b0;
            evicted_reg <= 1'b1;
        end
        if (cmd.fill)
        begin
            slot_reg    <= fill_slot;
            hit_reg     <= 1'b0;
            evicted_reg <= 1'b0;
            evkey_reg   <= '0;
            head_reg    <= fill_slot;
            if (status.empty)
                tail_reg <= fill_slot;
        end
        if (cmd.unlink)
        begin
            evkey_reg <= evicted_reg ? rd_key_reg : '0;
            if (!sel_head && sel_tail)
                tail_reg <= prev_q_reg;
        end
        if (cmd.relink)
            head_reg <= sel_reg;
    end

    assign res_hit         = hit_reg;
    assign res_slot        = SLOT_OUT_W'(slot_reg);
    assign res_evicted     = evicted_reg;
    assign res_evicted_key = evkey_reg;

endmodule

/* sv/lru_page_cache_lookup.sv */
// ----------------------------------------------------------------------------
// lru_page_cache_lookup
// Fully associative page tag store with least-recently-used replacement.
//
//   channel   signals                                   beat taken when
//   request   start, busy, page_key                     start & !busy
//   result    done, hit, slot, evicted, evicted_key     done
//   config    cfg_valid, cfg_ready, cfg_data            cfg_valid & cfg_ready
//
// one request at a time; keys are scanned one slot a cycle through a single
// read port; a hit, or an eviction of the least recent slot, is moved to the front;
// a miss with room takes the next free slot
// reset empties the cache and sets the capacity to 64, no clearing pass
// results are shown for the single cycle of done and cannot be stalled
// ----------------------------------------------------------------------------
module lru_page_cache_lookup #(
    parameter int SLOTS = lpc_pkg::DEF_SLOTS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [lpc_pkg::KEY_W-1:0]      page_key,
    output logic                           done,
    output logic                           hit,
    output logic [lpc_pkg::SLOT_OUT_W-1:0] slot,
    output logic                           evicted,
    output logic [lpc_pkg::KEY_W-1:0]      evicted_key,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [lpc_pkg::CAP_W-1:0]      cfg_data
);
    import lpc_pkg::*;

    lpc_cmd_t    cmd;
    lpc_status_t status;

    assign cfg_ready = !busy;

    lpc_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    lpc_datapath #(
        .SLOTS (SLOTS)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .page_key        (page_key),
        .cfg_we          (cfg_valid && cfg_ready),
        .cfg_data        (cfg_data),
        .res_hit         (hit),
        .res_slot        (slot),
        .res_evicted     (evicted),
        .res_evicted_key (evicted_key)
    );

    // one result beat per lookup, shown as the block goes idle
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held for two cycles");

    a_idle_with_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("lookup ended without a result beat");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not start a lookup");

    a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
        (done && hit) |-> !evicted)
        else $error("hit reported with an eviction");

    a_evkey_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !evicted) |-> (evicted_key == '0))
        else $error("evicted key nonzero without an eviction");

endmodule
